// File: rtl/core/obbsat_pkg.sv
// Package for the OBB separating axis test: widths, codes and shared types.
// Used by every module in rtl/core; no dependencies.
package obbsat_pkg;

    localparam int VERTS_PER_BOX = 8;
    localparam int AXES_PER_BOX  = 3;
    localparam int COORD_BITS    = 32;
    localparam int AXIS_BITS     = 16;

    localparam int NUM_VERTS   = 2 * VERTS_PER_BOX;
    localparam int NUM_AXES    = 2 * AXES_PER_BOX;
    localparam int VADDR_BITS  = $clog2(NUM_VERTS);
    localparam int AADDR_BITS  = $clog2(NUM_AXES);
    localparam int CROSS_BITS  = 2 * AXIS_BITS + 1;
    localparam int MPROD_BITS  = 2 * AXIS_BITS;
    localparam int SQ_BITS     = 2 * MPROD_BITS;
    localparam int LEN_BITS    = SQ_BITS + 2;
    localparam int PROD_BITS   = COORD_BITS + CROSS_BITS;
    localparam int SUM_BITS    = PROD_BITS + 2;
    localparam int THR_BITS    = 63;
    localparam int CAND_BITS   = 4;

    localparam logic [THR_BITS-1:0]  THR_RESET = 63'd72057594038;
    localparam logic [CAND_BITS-1:0] NUM_CAND  = 4'd15;
    localparam logic [CAND_BITS-1:0] LAST_CAND = 4'd14;
    localparam logic [CAND_BITS-1:0] FIRST_CROSS = 4'd6;

    localparam logic [1:0] OP_LOAD_VERT = 2'd0;
    localparam logic [1:0] OP_LOAD_AXIS = 2'd1;
    localparam logic [1:0] OP_TEST      = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vert;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] x;
        logic signed [AXIS_BITS-1:0] y;
        logic signed [AXIS_BITS-1:0] z;
    } t_axis;

    typedef struct packed {
        logic done;
        logic overlap;
    } t_proj_stat;

endpackage

// File: rtl/core/obbsat_vmem.sv
// Vertex memory: 16 entries, one write port, one registered read port.
// Depends on obbsat_pkg.
module obbsat_vmem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [obbsat_pkg::VADDR_BITS-1:0] i_waddr,
    input  obbsat_pkg::t_vert                 i_wdata,
    input  logic [obbsat_pkg::VADDR_BITS-1:0] i_raddr,
    output obbsat_pkg::t_vert                 o_rdata
);
    import obbsat_pkg::*;

    t_vert r_mem [NUM_VERTS];
    t_vert r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/obbsat_amem.sv
// Local axis memory: 6 entries, one write port, one registered read port.
// Depends on obbsat_pkg.
module obbsat_amem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [obbsat_pkg::AADDR_BITS-1:0] i_waddr,
    input  obbsat_pkg::t_axis                 i_wdata,
    input  logic [obbsat_pkg::AADDR_BITS-1:0] i_raddr,
    output obbsat_pkg::t_axis                 o_rdata
);
    import obbsat_pkg::*;

    t_axis r_mem [NUM_AXES];
    t_axis r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/obbsat_proj.sv
// Projection unit: walks the 16 vertices through a multiply/sum/min-max pipe
// and reports interval overlap. Depends on obbsat_pkg and obbsat_vmem data.
module obbsat_proj (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic signed [obbsat_pkg::CROSS_BITS-1:0] i_ax,
    input  logic signed [obbsat_pkg::CROSS_BITS-1:0] i_ay,
    input  logic signed [obbsat_pkg::CROSS_BITS-1:0] i_az,
    input  obbsat_pkg::t_vert                   i_vdata,
    output logic [obbsat_pkg::VADDR_BITS-1:0]   o_raddr,
    output obbsat_pkg::t_proj_stat              o_stat
);
    import obbsat_pkg::*;

    localparam logic [VADDR_BITS:0] CNT_FIRST = (VADDR_BITS+1)'(3);
    localparam logic [VADDR_BITS:0] CNT_LAST  = (VADDR_BITS+1)'(NUM_VERTS + 2);
    localparam logic [VADDR_BITS:0] CNT_END   = (VADDR_BITS+1)'(NUM_VERTS + 3);

    logic                    r_run;
    logic [VADDR_BITS:0]     r_cnt;
    logic signed [PROD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [SUM_BITS-1:0]  r_sum;
    logic signed [SUM_BITS-1:0]  r_lo [2];
    logic signed [SUM_BITS-1:0]  r_hi [2];
    logic [VADDR_BITS:0]     vidx;
    logic                    vbox;
    logic                    vfirst;
    logic                    upd;

    assign o_raddr = r_cnt[VADDR_BITS-1:0];
    assign vidx    = r_cnt - CNT_FIRST;
    assign vbox    = vidx[VADDR_BITS-1];
    assign vfirst  = (vidx[VADDR_BITS-2:0] == '0);
    assign upd     = r_run && (r_cnt >= CNT_FIRST) && (r_cnt <= CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_END) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= PROD_BITS'(i_vdata.x) * PROD_BITS'(i_ax);
        r_py  <= PROD_BITS'(i_vdata.y) * PROD_BITS'(i_ay);
        r_pz  <= PROD_BITS'(i_vdata.z) * PROD_BITS'(i_az);
        r_sum <= SUM_BITS'(r_px) + SUM_BITS'(r_py) + SUM_BITS'(r_pz);
        if (upd) begin
            if (vfirst || (r_sum < r_lo[vbox])) begin
                r_lo[vbox] <= r_sum;
            end
            if (vfirst || (r_sum > r_hi[vbox])) begin
                r_hi[vbox] <= r_sum;
            end
        end
    end

    assign o_stat = '{done:    r_run && (r_cnt == CNT_END),
                      overlap: !(r_hi[0] < r_lo[1]) && !(r_hi[1] < r_lo[0])};
endmodule

// File: rtl/core/obb_separating_axis_test.sv
// Top level of the OBB separating axis test: command decode, candidate axis
// sequencer and cross-product datapath. Depends on obbsat_pkg and submodules.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// Opcode 0 writes a vertex (box_select*8+slot_index), opcode 1 writes a
// local axis (slot 0..2), opcode 2 runs a test; opcode 3 is dropped.
// Loads leave busy low and give no result.
// A test walks up to 15 candidate axes. A face axis is read and then projected;
// a cross axis is read and multiplied, and it is projected only when its squared
// length is not below the threshold. The vertex memory port (one vertex per
// cycle) sets the projection time. A test holds busy high until its last axis
// is done; it ends early at the first separating axis. Its result shows for one
// cycle on o_result_valid with o_colliding and o_separating_axis; the receiver
// cannot stall.
// The threshold register is written through i_cfg_valid/o_cfg_ready at any
// time, but only while idle by contract. Reset returns to idle and restores
// the threshold; stored vertices and axes are undefined until loaded.
module obb_separating_axis_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic                              i_box_select,
    input  logic [2:0]                        i_slot_index,
    input  logic signed [31:0]                i_coord_x,
    input  logic signed [31:0]                i_coord_y,
    input  logic signed [31:0]                i_coord_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [obbsat_pkg::THR_BITS-1:0]   i_cfg_data,
    output logic                              o_result_valid,
    output logic                              o_colliding,
    output logic [3:0]                        o_separating_axis
);
    import obbsat_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ARD    = 4'd1;
    localparam logic [3:0] S_AFACE  = 4'd2;
    localparam logic [3:0] S_ARD2   = 4'd3;
    localparam logic [3:0] S_ACAP   = 4'd4;
    localparam logic [3:0] S_CMUL   = 4'd5;
    localparam logic [3:0] S_CSUB   = 4'd6;
    localparam logic [3:0] S_CSQ    = 4'd7;
    localparam logic [3:0] S_CCMP   = 4'd8;
    localparam logic [3:0] S_PSTART = 4'd9;
    localparam logic [3:0] S_PROJ   = 4'd10;

    logic [3:0]             r_state, n_state;
    logic [CAND_BITS-1:0]   r_cand;
    logic [1:0]             r_ci, r_cj;
    logic [THR_BITS-1:0]    r_thr;
    logic                   r_out_valid;
    logic                   r_coll;
    logic [CAND_BITS-1:0]   r_sep;
    t_axis                  r_a, r_b;
    logic signed [MPROD_BITS-1:0] r_m [6];
    logic signed [CROSS_BITS-1:0] r_ax, r_ay, r_az;
    logic [SQ_BITS-1:0]     r_sq [3];

    logic                   accept;
    logic                   vwe, awe;
    logic [VADDR_BITS-1:0]  vwaddr, vraddr;
    logic [AADDR_BITS-1:0]  awaddr, araddr;
    t_vert                  vwdata, vrdata;
    t_axis                  awdata, ardata;
    t_proj_stat             pstat;
    logic                   is_face;
    logic                   advance;
    logic                   finish_sep;
    logic [CROSS_BITS-1:0]  mag_x, mag_y, mag_z;
    logic [LEN_BITS-1:0]    len2;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign vwe    = accept && (i_opcode == OP_LOAD_VERT);
    assign vwaddr = {i_box_select, i_slot_index};
    assign vwdata = '{x: i_coord_x[COORD_BITS-1:0], y: i_coord_y[COORD_BITS-1:0],
                      z: i_coord_z[COORD_BITS-1:0]};

    assign awe    = accept && (i_opcode == OP_LOAD_AXIS)
                    && (i_slot_index < 3'(AXES_PER_BOX));
    assign awaddr = i_box_select ? AADDR_BITS'(AXES_PER_BOX) + i_slot_index[AADDR_BITS-1:0]
                                 : i_slot_index[AADDR_BITS-1:0];
    assign awdata = '{x: i_coord_x[AXIS_BITS-1:0], y: i_coord_y[AXIS_BITS-1:0],
                      z: i_coord_z[AXIS_BITS-1:0]};

    assign is_face = (r_cand < FIRST_CROSS);
    assign araddr  = (r_state == S_ARD2) ? AADDR_BITS'(AXES_PER_BOX) + AADDR_BITS'(r_cj)
                   : is_face ? r_cand[AADDR_BITS-1:0] : AADDR_BITS'(r_ci);

    obbsat_vmem u_vmem (
        .i_clk   (i_clk),
        .i_we    (vwe),
        .i_waddr (vwaddr),
        .i_wdata (vwdata),
        .i_raddr (vraddr),
        .o_rdata (vrdata)
    );

    obbsat_amem u_amem (
        .i_clk   (i_clk),
        .i_we    (awe),
        .i_waddr (awaddr),
        .i_wdata (awdata),
        .i_raddr (araddr),
        .o_rdata (ardata)
    );

    obbsat_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_state == S_PSTART),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_az    (r_az),
        .i_vdata (vrdata),
        .o_raddr (vraddr),
        .o_stat  (pstat)
    );

    assign mag_x = r_ax[CROSS_BITS-1] ? -r_ax : r_ax;
    assign mag_y = r_ay[CROSS_BITS-1] ? -r_ay : r_ay;
    assign mag_z = r_az[CROSS_BITS-1] ? -r_az : r_az;
    assign len2  = LEN_BITS'(r_sq[0]) + LEN_BITS'(r_sq[1]) + LEN_BITS'(r_sq[2]);

    assign finish_sep = (r_state == S_PROJ) && pstat.done && !pstat.overlap;
    assign advance    = ((r_state == S_PROJ) && pstat.done && pstat.overlap)
                     || ((r_state == S_CCMP) && (len2 < LEN_BITS'(r_thr)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && (i_opcode == OP_TEST)) n_state = S_ARD;
            S_ARD:    n_state = is_face ? S_AFACE : S_ARD2;
            S_AFACE:  n_state = S_PSTART;
            S_ARD2:   n_state = S_ACAP;
            S_ACAP:   n_state = S_CMUL;
            S_CMUL:   n_state = S_CSUB;
            S_CSUB:   n_state = S_CSQ;
            S_CSQ:    n_state = S_CCMP;
            S_CCMP:   n_state = S_PSTART;
            S_PSTART: n_state = S_PROJ;
            S_PROJ:   if (finish_sep) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (advance) begin
            n_state = (r_cand == LAST_CAND) ? S_IDLE : S_ARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
            r_cand      <= '0;
            r_ci        <= '0;
            r_cj        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (accept && (i_opcode == OP_TEST)) begin
                r_cand <= '0;
                r_ci   <= '0;
                r_cj   <= '0;
            end
            if (finish_sep) begin
                r_out_valid <= 1'b1;
                r_coll      <= 1'b0;
                r_sep       <= r_cand;
            end
            if (advance) begin
                if (r_cand == LAST_CAND) begin
                    r_out_valid <= 1'b1;
                    r_coll      <= 1'b1;
                    r_sep       <= NUM_CAND;
                end
                r_cand <= r_cand + 1'b1;
                if (!is_face) begin
                    if (r_cj == 2'(AXES_PER_BOX - 1)) begin
                        r_cj <= '0;
                        r_ci <= r_ci + 1'b1;
                    end else begin
                        r_cj <= r_cj + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ARD2) r_a <= ardata;
        if (r_state == S_ACAP) r_b <= ardata;
        r_m[0] <= MPROD_BITS'(r_a.y) * MPROD_BITS'(r_b.z);
        r_m[1] <= MPROD_BITS'(r_a.z) * MPROD_BITS'(r_b.y);
        r_m[2] <= MPROD_BITS'(r_a.z) * MPROD_BITS'(r_b.x);
        r_m[3] <= MPROD_BITS'(r_a.x) * MPROD_BITS'(r_b.z);
        r_m[4] <= MPROD_BITS'(r_a.x) * MPROD_BITS'(r_b.y);
        r_m[5] <= MPROD_BITS'(r_a.y) * MPROD_BITS'(r_b.x);
        if (r_state == S_AFACE) begin
            r_ax <= CROSS_BITS'(ardata.x);
            r_ay <= CROSS_BITS'(ardata.y);
            r_az <= CROSS_BITS'(ardata.z);
        end else if (r_state == S_CSUB) begin
            r_ax <= CROSS_BITS'(r_m[0]) - CROSS_BITS'(r_m[1]);
            r_ay <= CROSS_BITS'(r_m[2]) - CROSS_BITS'(r_m[3]);
            r_az <= CROSS_BITS'(r_m[4]) - CROSS_BITS'(r_m[5]);
        end
        r_sq[0] <= SQ_BITS'(mag_x[MPROD_BITS-1:0]) * SQ_BITS'(mag_x[MPROD_BITS-1:0]);
        r_sq[1] <= SQ_BITS'(mag_y[MPROD_BITS-1:0]) * SQ_BITS'(mag_y[MPROD_BITS-1:0]);
        r_sq[2] <= SQ_BITS'(mag_z[MPROD_BITS-1:0]) * SQ_BITS'(mag_z[MPROD_BITS-1:0]);
    end

    assign o_result_valid    = r_out_valid;
    assign o_colliding       = r_coll;
    assign o_separating_axis = r_sep;

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_colliding == (o_separating_axis == NUM_CAND)))
        else $error("colliding flag and axis code disagree");

    a_proj_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pstat.done |-> (r_state == S_PROJ))
        else $error("projection finished outside projection state");

    a_no_mem_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vwe || awe) |-> (r_state == S_IDLE))
        else $error("store written during a test");
endmodule

// File: tb/sv/obb_separating_axis_test_tb.sv
// Self-checking testbench for obb_separating_axis_test: loads random and
// hand-picked boxes, runs collision tests and checks every result against
// an in-bench separating-axis predictor. Depends on obbsat_pkg and the RTL.
class sat_scoreboard;
    typedef struct {
        logic       colliding;
        logic [3:0] sep_axis;
    } t_sat_verdict;

    logic signed [obbsat_pkg::COORD_BITS-1:0] vx[16], vy[16], vz[16];
    logic signed [obbsat_pkg::AXIS_BITS-1:0]  ax[6], ay[6], az[6];
    logic [obbsat_pkg::THR_BITS-1:0]          threshold;
    t_sat_verdict                             verdicts[$];
    int                                       errors;

    function new();
        threshold = obbsat_pkg::THR_RESET;
        errors    = 0;
    endfunction

    function void set_threshold(logic [62:0] v);
        threshold = v;
    endfunction

    function int pending();
        return verdicts.size();
    endfunction

    function bit overlaps(logic signed [32:0] dx, logic signed [32:0] dy,
                          logic signed [32:0] dz);
        logic signed [127:0] lo[2], hi[2], p, px, py, pz, ex, ey, ez;
        int k;
        ex = dx;
        ey = dy;
        ez = dz;
        for (int b = 0; b < 2; b++) begin
            for (int v = 0; v < 8; v++) begin
                k  = b * 8 + v;
                px = vx[k];
                py = vy[k];
                pz = vz[k];
                p  = px * ex + py * ey + pz * ez;
                if (v == 0 || p < lo[b]) lo[b] = p;
                if (v == 0 || p > hi[b]) hi[b] = p;
            end
        end
        return !(hi[0] < lo[1]) && !(hi[1] < lo[0]);
    endfunction

    function void note_input(logic [1:0] op, logic box, logic [2:0] slot,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [32:0] cx, cy, cz;
        logic signed [67:0] len2;
        t_sat_verdict       vd;
        int                 sep, k;
        if (op == obbsat_pkg::OP_LOAD_VERT) begin
            k = box * 8 + slot;
            vx[k] = x;
            vy[k] = y;
            vz[k] = z;
        end else if (op == obbsat_pkg::OP_LOAD_AXIS) begin
            if (slot < 3) begin
                k = box * 3 + slot;
                ax[k] = x[15:0];
                ay[k] = y[15:0];
                az[k] = z[15:0];
            end
        end else if (op == obbsat_pkg::OP_TEST) begin
            sep = 15;
            for (int n = 0; n < 6 && sep == 15; n++)
                if (!overlaps(ax[n], ay[n], az[n])) sep = n;
            for (int i = 0; i < 3 && sep == 15; i++) begin
                for (int j = 0; j < 3 && sep == 15; j++) begin
                    cx = ay[i] * az[3+j] - az[i] * ay[3+j];
                    cy = az[i] * ax[3+j] - ax[i] * az[3+j];
                    cz = ax[i] * ay[3+j] - ay[i] * ax[3+j];
                    len2 = cx * cx + cy * cy + cz * cz;
                    if (len2 < $signed({5'b0, threshold})) continue;
                    if (!overlaps(cx, cy, cz)) sep = 6 + 3 * i + j;
                end
            end
            vd.colliding = (sep == 15);
            vd.sep_axis  = sep[3:0];
            verdicts = {verdicts, vd};
        end
    endfunction

    function void check_result(logic colliding, logic [3:0] sep_axis);
        t_sat_verdict vd;
        if (verdicts.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: colliding=%0d axis=%0d",
                                       colliding, sep_axis);
            return;
        end
        vd = verdicts.pop_front();
        if (vd.colliding !== colliding || vd.sep_axis !== sep_axis) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected colliding=%0d axis=%0d, got colliding=%0d axis=%0d",
                         vd.colliding, vd.sep_axis, colliding, sep_axis);
        end
    endfunction
endclass

module obb_separating_axis_test_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import obbsat_pkg::*;

    logic        i_clk, i_rst_n, start, busy;
    logic [1:0]  i_opcode;
    logic        i_box_select;
    logic [2:0]  i_slot_index;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z;
    logic        i_cfg_valid, o_cfg_ready;
    logic [THR_BITS-1:0] i_cfg_data;
    logic        o_result_valid, o_colliding;
    logic [3:0]  o_separating_axis;

    sat_scoreboard sb;
    int          items_sent;
    int          idle_count;
    bit          no_gaps;

    obb_separating_axis_test uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_box_select(i_box_select), .i_slot_index(i_slot_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_colliding(o_colliding),
        .o_separating_axis(o_separating_axis)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_colliding, o_separating_axis);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= 20000) begin
                $display("obb_separating_axis_test_tb NOT OK");
                $finish;
            end
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [1:0] op, logic box, logic [2:0] slot,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_box_select <= box;
        i_slot_index <= slot;
        i_coord_x    <= x;
        i_coord_y    <= y;
        i_coord_z    <= z;
        do @(posedge i_clk); while (busy);
        sb.note_input(op, box, slot, x, y, z);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [62:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_threshold(v);
        i_cfg_valid <= 1'b0;
    endtask

    function logic [31:0] rand_axis_comp();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return {r[31:16], 16'h0000};
            1: return {r[31:16], 16'h4000};
            2: return {r[31:16], 16'hC000};
            default: return {r[31:16], 16'($signed($urandom_range(0, 32768)) - 16384)};
        endcase
    endfunction

    // one box: center plus bounded offsets, axes loosely random or reused from axs
    task automatic load_box(logic box, int cx, int cy, int cz, bit copy_axes,
                            ref logic [31:0] axs[9]);
        int ext;
        ext = 1 << $urandom_range(10, 18);
        for (int v = 0; v < 8; v++)
            send_item(OP_LOAD_VERT, box, v[2:0],
                      cx + $signed($urandom_range(0, 2 * ext)) - ext,
                      cy + $signed($urandom_range(0, 2 * ext)) - ext,
                      cz + $signed($urandom_range(0, 2 * ext)) - ext);
        for (int a = 0; a < 3; a++) begin
            if (!copy_axes) begin
                axs[3*a]   = rand_axis_comp();
                axs[3*a+1] = rand_axis_comp();
                axs[3*a+2] = rand_axis_comp();
            end
            send_item(OP_LOAD_AXIS, box, a[2:0], axs[3*a], axs[3*a+1], axs[3*a+2]);
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(2'd3, 1'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
            1: send_item(OP_LOAD_AXIS, 1'($urandom), 3'($urandom_range(3, 7)),
                         $urandom, $urandom, $urandom);
            2: send_item(OP_LOAD_VERT, 1'($urandom), 3'($urandom),
                         $urandom, $urandom, $urandom);
            default: send_item(OP_LOAD_AXIS, 1'($urandom), 3'($urandom_range(0, 2)),
                               $urandom, $urandom, $urandom);
        endcase
    endtask

    task automatic run_batch();
        logic [31:0] axs[9];
        int cx, cy, cz, spread;
        if ($urandom_range(0, 99) < 80) begin
            cx     = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            cy     = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            cz     = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            spread = 1 << $urandom_range(16, 21);
            load_box(1'b0, cx, cy, cz, 1'b0, axs);
            load_box(1'b1, cx + $signed($urandom_range(0, 2 * spread)) - spread,
                     cy + $signed($urandom_range(0, 2 * spread)) - spread,
                     cz + $signed($urandom_range(0, 2 * spread)) - spread,
                     $urandom_range(0, 3) == 0, axs);
            repeat ($urandom_range(0, 2)) send_noise();
        end else begin
            repeat ($urandom_range(1, 6)) send_noise();
        end
        send_item(OP_TEST, 1'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [31:0] ext;
        logic [62:0] thr_set[5];
        sb           = new();
        items_sent   = 0;
        no_gaps      = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = '0;
        i_box_select = 1'b0;
        i_slot_index = '0;
        i_coord_x    = '0;
        i_coord_y    = '0;
        i_coord_z    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes: full-scale vertices, full-scale and zero axes
        for (int k = 0; k < 16; k++) begin
            ext = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            send_item(OP_LOAD_VERT, k[3], k[2:0], ext, ~ext, k[1] ? ext : 32'h0);
        end
        send_item(OP_LOAD_AXIS, 1'b0, 3'd0, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0);
        send_item(OP_LOAD_AXIS, 1'b0, 3'd1, 32'h0, 32'h0, 32'h0);
        send_item(OP_LOAD_AXIS, 1'b0, 3'd2, 32'hFFFF_8000, 32'h0000_7FFF, 32'h0000_7FFF);
        send_item(OP_LOAD_AXIS, 1'b1, 3'd0, 32'h7FFF_8000, 32'h0000_4000, 32'hFFFF_C000);
        send_item(OP_LOAD_AXIS, 1'b1, 3'd1, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0);
        send_item(OP_LOAD_AXIS, 1'b1, 3'd2, 32'h0, 32'h0000_4000, 32'h0);
        send_item(OP_LOAD_AXIS, 1'b1, 3'd7, 32'h1234_5678, 32'h0, 32'h0);
        send_item(2'd3, 1'b1, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_TEST, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0);

        thr_set[0] = 63'd0;
        thr_set[1] = 63'h7FFF_FFFF_FFFF_FFFF;
        thr_set[2] = 63'({$urandom, $urandom} >> $urandom_range(1, 40));
        thr_set[3] = THR_RESET;
        thr_set[4] = 63'd1 << 54;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_threshold(thr_set[ph-1]);
            no_gaps = (ph == 2);
            while (items_sent < 25 + (ph + 1) * 265) run_batch();
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("obb_separating_axis_test_tb OK");
        end else begin
            $display("obb_separating_axis_test_tb NOT OK");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/obbsat_pkg.sv
rtl/core/obbsat_vmem.sv
rtl/core/obbsat_amem.sv
rtl/core/obbsat_proj.sv
rtl/core/obb_separating_axis_test.sv
tb/sv/obb_separating_axis_test_tb.sv
